### rtl/core/erq_pkg.sv
// Shared types and constants for the elevator request queue.
package erq_pkg;

	// Command codes of an input item.
	localparam logic CMD_INSERT   = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_INSERTED   = 2'd0;
	localparam logic [1:0] ST_FULL       = 2'd1;
	localparam logic [1:0] ST_DISPATCHED = 2'd2;
	localparam logic [1:0] ST_EMPTY      = 2'd3;

	// Configuration register indexes.
	localparam logic REG_SAWTOOTH    = 1'b0;
	localparam logic REG_READS_FIRST = 1'b1;

	// Walk phases of the insertion scan.
	typedef enum logic [2:0] {
		PH_SKIP,
		PH_ASC_LE,
		PH_ASC_RUN,
		PH_ASC_GE,
		PH_DSC_GE,
		PH_DSC_RUN,
		PH_DSC_LE,
		PH_PRIO
	} phase_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input item
		logic scan_start; // begin a scan at the head
		logic scan_step;  // evaluate the current pair and advance or stop
		logic ins_write;  // write the new entry at the found slot
		logic deq_write;  // remove the head
		logic out_load;   // capture the result
	} erq_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_dispatch;
		logic full;
		logic empty;
		logic scan_done;
	} erq_stat_t;

endpackage

### rtl/core/erq_if.sv
// Valid/ready channel interfaces for items, results and configuration writes.
interface erq_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  req_tag;
	logic [15:0] req_cylinder;
	logic        req_is_read;
	modport source (output valid, cmd, req_tag, req_cylinder, req_is_read, input ready);
	modport sink   (input valid, cmd, req_tag, req_cylinder, req_is_read, output ready);
endinterface

interface erq_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  out_tag;
	logic [15:0] out_cylinder;
	logic        out_is_read;
	logic [4:0]  occupancy;
	modport source (output valid, status, out_tag, out_cylinder, out_is_read, occupancy,
		input ready);
	modport sink   (input valid, status, out_tag, out_cylinder, out_is_read, occupancy,
		output ready);
endinterface

interface erq_cfg_if;
	logic valid;
	logic ready;
	logic index;
	logic data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/elevator_request_queue.sv
// Top level of the elevator request queue.
//  channel | role  | transfer
//  items   | sink  | cmd, req_tag, req_cylinder, req_is_read
//  results | src   | status, out_tag, out_cylinder, out_is_read, occupancy
//  cfg     | sink  | index, data (always ready)
// Dispatch or rejected insert: the decide state after the transfer loads the result.
// Insert: decide, then the scan steps, then the shift state that writes the entry and loads the result.
// The scan walks the queue one entry pair a cycle; that loop sets the rate.
// Reset empties the queue and sets sawtooth mode; a pending result holds under stall.
module elevator_request_queue
	import erq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int CYL_BITS    = 16,
	parameter int TAG_BITS    = 8
) (
	input logic  clk,
	input logic  arst_n,
	erq_in_if.sink   items,
	erq_out_if.source results,
	erq_cfg_if.sink  cfg
);

	erq_cmd_t  cmd;
	erq_stat_t stat;
	logic      saw_q, rf_q;

	// Configuration registers.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			saw_q <= 1'b1;
			rf_q  <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SAWTOOTH:    saw_q <= cfg.data;
				REG_READS_FIRST: rf_q  <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	erq_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (items.valid), .in_ready (items.ready),
		.out_valid(results.valid), .out_ready(results.ready),
		.stat, .cmd
	);

	erq_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH), .CYL_BITS(CYL_BITS), .TAG_BITS(TAG_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .stat,
		.in_cmd(items.cmd), .in_tag(items.req_tag), .in_cyl(items.req_cylinder),
		.in_read(items.req_is_read), .sawtooth(saw_q), .reads_first(rf_q),
		.status(results.status), .out_tag(results.out_tag),
		.out_cylinder(results.out_cylinder), .out_is_read(results.out_is_read),
		.occupancy(results.occupancy)
	);

endmodule

### rtl/core/erq_ctrl.sv
// Controller state machine of the elevator request queue.
module erq_ctrl
	import erq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  erq_stat_t stat,
	output erq_cmd_t  cmd
);

	typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_SCAN, S_SHIFT, S_DONE} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign out_valid = out_valid_q;
	// A new item may enter while idle once the previous result slot is free or leaving.
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);

	// Commands decoded from the state.
	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && in_valid && in_ready;
		unique case (state_q)
			S_IDLE: begin
			end
			S_DECIDE: begin
				if (!stat.is_dispatch && !stat.full) cmd.scan_start = 1'b1;
				if (stat.is_dispatch || stat.full) cmd.out_load = 1'b1;
				if (stat.is_dispatch && !stat.empty) cmd.deq_write = 1'b1;
			end
			S_SCAN: begin
				if (!stat.scan_done) cmd.scan_step = 1'b1;
			end
			S_SHIFT: begin
				cmd.ins_write = 1'b1;
				cmd.out_load  = 1'b1;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (stat.is_dispatch || stat.full) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (stat.scan_done) state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/erq_datapath.sv
// Datapath of the elevator request queue: entry registers, scan walker, result register.
module erq_datapath
	import erq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16,
	parameter int CYL_BITS    = 16,
	parameter int TAG_BITS    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  erq_cmd_t    cmd,
	output erq_stat_t   stat,
	input  logic        in_cmd,
	input  logic [7:0]  in_tag,
	input  logic [15:0] in_cyl,
	input  logic        in_read,
	input  logic        sawtooth,
	input  logic        reads_first,
	output logic [1:0]  status,
	output logic [7:0]  out_tag,
	output logic [15:0] out_cylinder,
	output logic        out_is_read,
	output logic [4:0]  occupancy
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [TAG_BITS-1:0] tag_q [QUEUE_DEPTH];
	logic [CYL_BITS-1:0] cyl_q [QUEUE_DEPTH];
	logic                rd_q  [QUEUE_DEPTH];
	logic [CW-1:0]       count_q;

	logic                new_cmd_q;
	logic [TAG_BITS-1:0] new_tag_q;
	logic [CYL_BITS-1:0] new_cyl_q;
	logic                new_rd_q;

	logic [CW-1:0]       p_q;
	logic [CW-1:0]       pos_q;
	phase_t              ph_q;
	logic                done_q;

	logic [1:0]          st_q;
	logic [7:0]          otag_q;
	logic [15:0]         ocyl_q;
	logic                ord_q;

	// Truncated input fields.
	logic [TAG_BITS-1:0] in_tag_t;
	logic [CYL_BITS-1:0] in_cyl_t;
	logic [15:0]         in_cyl_w;
	logic [31:0]         in_tag_w;
	assign in_cyl_w = in_cyl;
	assign in_tag_w = {24'd0, in_tag};
	always_comb begin
		in_cyl_t = '0;
		in_tag_t = in_tag_w[TAG_BITS-1:0];
		for (int b = 0; b < CYL_BITS; b++) begin
			if (b < 16) in_cyl_t[b] = in_cyl_w[b];
		end
	end

	// Pair under evaluation: slot p and slot p + 1.
	logic [CW-1:0]       q_w;
	logic [IW-1:0]       pi, qi;
	logic [CYL_BITS-1:0] pc, qc, nc;
	logic                q_valid;
	logic [CYL_BITS-1:0] d_new, d_q;
	logic                closer, ahead;

	assign q_w     = p_q + CW'(1);
	assign q_valid = q_w < count_q;
	assign pi      = p_q[IW-1:0];
	assign qi      = q_valid ? q_w[IW-1:0] : p_q[IW-1:0];
	assign pc      = cyl_q[pi];
	assign qc      = cyl_q[qi];
	assign nc      = new_cyl_q;
	assign d_new   = (pc > nc) ? pc - nc : nc - pc;
	assign d_q     = (pc > qc) ? pc - qc : qc - pc;
	assign closer  = d_new < d_q;
	always_comb begin
		if (!reads_first) ahead = closer;
		else if (new_rd_q) ahead = !rd_q[qi] || closer;
		else ahead = !rd_q[qi] && closer;
	end

	// One walk step: either advance p or settle the slot at q.
	logic   adv, stop;
	phase_t ph_n;
	always_comb begin
		adv  = 1'b0;
		stop = 1'b0;
		ph_n = ph_q;
		case (ph_q)
			PH_SKIP: begin
				if (!q_valid) stop = 1'b1;
				else if (pc == qc) adv = 1'b1;
				else if (!sawtooth) ph_n = PH_PRIO;
				else if (pc < qc) ph_n = (pc <= nc) ? PH_ASC_LE : PH_ASC_RUN;
				else ph_n = (pc >= nc) ? PH_DSC_GE : PH_DSC_RUN;
			end
			PH_ASC_LE: begin
				if (q_valid && qc <= nc && pc <= qc) adv = 1'b1;
				else stop = 1'b1;
			end
			PH_ASC_RUN: begin
				// First advance is unconditional; then follow the rising run.
				adv  = 1'b1;
				ph_n = PH_ASC_GE;
				if (q_w + CW'(1) < count_q && !(qc <= cyl_q[IW'(q_w + CW'(1))]))
					ph_n = PH_ASC_GE;
				else if (q_w + CW'(1) < count_q)
					ph_n = PH_ASC_RUN;
			end
			PH_ASC_GE: begin
				if (q_valid && qc >= nc) adv = 1'b1;
				else stop = 1'b1;
			end
			PH_DSC_GE: begin
				if (q_valid && qc >= nc && pc >= qc) adv = 1'b1;
				else stop = 1'b1;
			end
			PH_DSC_RUN: begin
				adv  = 1'b1;
				ph_n = PH_DSC_LE;
				if (q_w + CW'(1) < count_q && qc >= cyl_q[IW'(q_w + CW'(1))])
					ph_n = PH_DSC_RUN;
			end
			PH_DSC_LE: begin
				if (q_valid && qc <= nc) adv = 1'b1;
				else stop = 1'b1;
			end
			PH_PRIO: begin
				if (!q_valid || ahead) stop = 1'b1;
				else adv = 1'b1;
			end
			default: stop = 1'b1;
		endcase
	end

	assign stat.is_dispatch = new_cmd_q;
	assign stat.full        = count_q >= CW'(QUEUE_DEPTH);
	assign stat.empty       = count_q == '0;
	assign stat.scan_done   = done_q;

	// Captured item and walker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			ph_q   <= PH_SKIP;
			p_q    <= '0;
			pos_q  <= '0;
		end else begin
			if (cmd.scan_start) begin
				p_q    <= '0;
				ph_q   <= PH_SKIP;
				done_q <= count_q == '0;
				pos_q  <= '0;
			end else if (cmd.scan_step) begin
				ph_q <= ph_n;
				if (adv) p_q <= q_w;
				if (stop) begin
					done_q <= 1'b1;
					pos_q  <= q_valid ? q_w : count_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_cmd_q <= in_cmd;
			new_tag_q <= in_tag_t;
			new_cyl_q <= in_cyl_t;
			new_rd_q  <= in_read;
		end
	end

	// Entry storage: parallel shift for insert and head removal.
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (cmd.ins_write) begin
				if (CW'(i) == pos_q) begin
					tag_q[i] <= new_tag_q;
					cyl_q[i] <= new_cyl_q;
					rd_q[i]  <= new_rd_q;
				end else if (CW'(i) > pos_q && i > 0) begin
					tag_q[i] <= tag_q[i-1];
					cyl_q[i] <= cyl_q[i-1];
					rd_q[i]  <= rd_q[i-1];
				end
			end else if (cmd.deq_write && i + 1 < QUEUE_DEPTH) begin
				tag_q[i] <= tag_q[i+1];
				cyl_q[i] <= cyl_q[i+1];
				rd_q[i]  <= rd_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins_write) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.deq_write) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			otag_q <= '0;
			ocyl_q <= '0;
			ord_q  <= 1'b0;
			if (cmd.ins_write) st_q <= ST_INSERTED;
			else if (!new_cmd_q) st_q <= ST_FULL;
			else if (count_q == '0) st_q <= ST_EMPTY;
			else begin
				st_q   <= ST_DISPATCHED;
				otag_q <= 8'(tag_q[0]);
				ocyl_q <= 16'(cyl_q[0]);
				ord_q  <= rd_q[0];
			end
		end
	end

	logic [CW-1:0] occ_w;
	assign occ_w        = count_q;
	assign status       = st_q;
	assign out_tag      = otag_q;
	assign out_cylinder = ocyl_q;
	assign out_is_read  = ord_q;
	assign occupancy    = 5'(occ_w);

endmodule
